/* rtl/cbm_pkg.sv */
`timescale 1ns / 1ps

package cbm_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_PPU   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    TGT_OPEN_BUS = 3'd0,
    TGT_PRG_ROM  = 3'd1,
    TGT_PRG_RAM  = 3'd2,
    TGT_CHR      = 3'd3,
    TGT_CIRAM    = 3'd4,
    TGT_NONE     = 3'd5
  } target_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  data;
  } item_t;

  // IRQ register write strobes decoded from the command port
  typedef struct packed {
    logic       ctrl;
    logic       cnt_lo;
    logic       cnt_hi;
    logic [7:0] data;
  } irq_wr_t;

  // CPU address windows, address[15:13]
  localparam logic [2:0] WIN_RAM  = 3'd3;
  localparam logic [2:0] WIN_8000 = 3'd4;
  localparam logic [2:0] WIN_A000 = 3'd5;
  localparam logic [2:0] WIN_C000 = 3'd6;
  localparam logic [2:0] WIN_E000 = 3'd7;

  localparam logic [5:0] PRG_FIXED_BANK = 6'h3f;

  // command register numbers
  localparam logic [3:0] CMD_PRG0     = 4'd8;
  localparam logic [3:0] CMD_PRG1     = 4'd9;
  localparam logic [3:0] CMD_PRG2     = 4'd10;
  localparam logic [3:0] CMD_PRG3     = 4'd11;
  localparam logic [3:0] CMD_MIRROR   = 4'd12;
  localparam logic [3:0] CMD_IRQ_CTRL = 4'd13;
  localparam logic [3:0] CMD_IRQ_LO   = 4'd14;
  localparam logic [3:0] CMD_IRQ_HI   = 4'd15;

  // audio register numbers
  localparam logic [3:0] AUD_MUTE = 4'd7;
  localparam logic [3:0] AUD_VOL0 = 4'd8;

  localparam logic [1:0] MIR_VERT    = 2'd0;
  localparam logic [1:0] MIR_HORZ    = 2'd1;
  localparam logic [1:0] MIR_SCREEN0 = 2'd2;
  localparam logic [1:0] MIR_SCREEN1 = 2'd3;

  localparam int MAX_TONES = 3;

  // 8192 / 2^((15-n)/2), truncated
  localparam logic [13:0] LEVEL_TABLE [16] = '{
    14'd45,   14'd64,   14'd90,   14'd128,
    14'd181,  14'd256,  14'd362,  14'd512,
    14'd724,  14'd1024, 14'd1448, 14'd2048,
    14'd2896, 14'd4096, 14'd5792, 14'd8192
  };

endpackage

/* rtl/cbm_map.sv */
`timescale 1ns / 1ps

module cbm_map (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  cbm_pkg::item_t      item,
  output cbm_pkg::target_t    target_next,
  output logic [18:0]         mapped_next,
  output logic                ram_write_next,
  output cbm_pkg::irq_wr_t    irq_wr
);

  logic [3:0] command_select;
  logic [7:0] prg_page [4];
  logic [7:0] chr_page [8];
  logic [1:0] mirror_mode;

  logic [2:0] win;
  logic       is_rd;
  logic       is_wr;
  logic       cmd_wr;
  logic [7:0] bank;
  logic [9:0] low;

  assign win    = item.address[15:13];
  assign is_rd  = (item.kind == cbm_pkg::KIND_READ);
  assign is_wr  = (item.kind == cbm_pkg::KIND_WRITE);
  assign cmd_wr = is_wr && (win == cbm_pkg::WIN_A000);
  assign low    = item.address[9:0];

  assign irq_wr.ctrl   = cmd_wr && (command_select == cbm_pkg::CMD_IRQ_CTRL);
  assign irq_wr.cnt_lo = cmd_wr && (command_select == cbm_pkg::CMD_IRQ_LO);
  assign irq_wr.cnt_hi = cmd_wr && (command_select == cbm_pkg::CMD_IRQ_HI);
  assign irq_wr.data   = item.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      command_select <= '0;
      mirror_mode    <= cbm_pkg::MIR_VERT;
      for (int i = 0; i < 4; i++) prg_page[i] <= '0;
      for (int i = 0; i < 8; i++) chr_page[i] <= '0;
    end else if (adv && is_wr) begin
      if (win == cbm_pkg::WIN_8000) begin
        command_select <= item.data[3:0];
      end else if (cmd_wr) begin
        if (!command_select[3]) begin
          chr_page[command_select[2:0]] <= item.data;
        end else begin
          case (command_select)
            cbm_pkg::CMD_PRG0, cbm_pkg::CMD_PRG1,
            cbm_pkg::CMD_PRG2, cbm_pkg::CMD_PRG3: begin
              prg_page[command_select[1:0]] <= item.data;
            end
            cbm_pkg::CMD_MIRROR: begin
              mirror_mode <= item.data[1:0];
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    target_next    = cbm_pkg::TGT_NONE;
    mapped_next    = '0;
    ram_write_next = 1'b0;
    bank           = prg_page[0];
    case (item.kind)
      cbm_pkg::KIND_READ, cbm_pkg::KIND_WRITE: begin
        if (win < cbm_pkg::WIN_RAM) begin
          target_next = is_rd ? cbm_pkg::TGT_OPEN_BUS : cbm_pkg::TGT_NONE;
        end else if (win == cbm_pkg::WIN_RAM) begin
          if (bank[6]) begin
            if (bank[7]) begin
              target_next    = cbm_pkg::TGT_PRG_RAM;
              mapped_next    = {bank[5:0], item.address[12:0]};
              ram_write_next = is_wr;
            end else begin
              target_next = is_rd ? cbm_pkg::TGT_OPEN_BUS : cbm_pkg::TGT_NONE;
            end
          end else if (is_rd) begin
            target_next = cbm_pkg::TGT_PRG_ROM;
            mapped_next = {bank[5:0], item.address[12:0]};
          end
        end else if (is_rd) begin
          case (win)
            cbm_pkg::WIN_8000: bank = prg_page[1];
            cbm_pkg::WIN_A000: bank = prg_page[2];
            cbm_pkg::WIN_C000: bank = prg_page[3];
            default:           bank = {2'b00, cbm_pkg::PRG_FIXED_BANK};
          endcase
          target_next = cbm_pkg::TGT_PRG_ROM;
          mapped_next = {bank[5:0], item.address[12:0]};
        end
      end
      cbm_pkg::KIND_PPU: begin
        if (item.address[13]) begin
          target_next = cbm_pkg::TGT_CIRAM;
          case (mirror_mode)
            cbm_pkg::MIR_VERT:    mapped_next = {8'd0, item.address[10], low};
            cbm_pkg::MIR_HORZ:    mapped_next = {8'd0, item.address[11], low};
            cbm_pkg::MIR_SCREEN0: mapped_next = {9'd0, low};
            default:              mapped_next = {8'd0, 1'b1, low};
          endcase
        end else begin
          target_next = cbm_pkg::TGT_CHR;
          mapped_next = {1'b0, chr_page[item.address[12:10]], low};
        end
      end
      default: ;
    endcase
  end

  a_ram_write_target: assert property (@(posedge clk) disable iff (rst)
    ram_write_next |-> (target_next == cbm_pkg::TGT_PRG_RAM) && is_wr)
    else $error("ram write outside prg ram window");

endmodule

/* rtl/cbm_irq.sv */
`timescale 1ns / 1ps

module cbm_irq (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             tick,
  input  cbm_pkg::irq_wr_t irq_wr,
  output logic             level_next
);

  logic        irq_enabled;
  logic        count_enabled;
  logic [15:0] count;
  logic        level;

  logic        irq_enabled_next;
  logic        count_enabled_next;
  logic [15:0] count_next;

  always_comb begin
    irq_enabled_next   = irq_enabled;
    count_enabled_next = count_enabled;
    count_next         = count;
    level_next         = level;
    if (tick) begin
      if (count_enabled) begin
        count_next = count - 16'd1;
        // wrap past zero
        if (count == 16'd0) level_next = irq_enabled;
      end
    end else if (irq_wr.ctrl) begin
      irq_enabled_next   = irq_wr.data[7];
      count_enabled_next = irq_wr.data[0];
      level_next         = 1'b0;
    end else if (irq_wr.cnt_lo) begin
      count_next = {count[15:8], irq_wr.data};
    end else if (irq_wr.cnt_hi) begin
      count_next = {irq_wr.data, count[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_enabled   <= 1'b0;
      count_enabled <= 1'b0;
      count         <= '0;
      level         <= 1'b0;
    end else if (adv) begin
      irq_enabled   <= irq_enabled_next;
      count_enabled <= count_enabled_next;
      count         <= count_next;
      level         <= level_next;
    end
  end

  a_irq_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(level) |-> $past(adv && tick && count_enabled && irq_enabled && count == 16'd0))
    else $error("irq raised without counter wrap");

endmodule

/* rtl/cbm_tone.sv */
`timescale 1ns / 1ps

module cbm_tone #(
  parameter int TONE_CHANNELS = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  cbm_pkg::item_t     item,
  output logic signed [15:0] sample_next
);

  logic [3:0]  audio_select;
  logic [11:0] period    [TONE_CHANNELS];
  logic        muted     [TONE_CHANNELS];
  logic [3:0]  volume    [TONE_CHANNELS];
  logic [15:0] countdown [TONE_CHANNELS];
  logic        phase     [TONE_CHANNELS];
  logic [3:0]  lvl       [TONE_CHANNELS];

  logic        tick;
  logic        aud_wr;
  logic [14:0] sum;

  assign tick   = (item.kind == cbm_pkg::KIND_TICK);
  assign aud_wr = adv && (item.kind == cbm_pkg::KIND_WRITE) &&
                  (item.address[15:13] == cbm_pkg::WIN_E000);

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_select <= '0;
    end else if (adv && (item.kind == cbm_pkg::KIND_WRITE) &&
                 (item.address[15:13] == cbm_pkg::WIN_C000)) begin
      audio_select <= item.data[3:0];
    end
  end

  for (genvar ch = 0; ch < TONE_CHANNELS; ch++) begin : g_ch
    logic [15:0] cd_dec;
    logic        wrap;
    logic        phase_new;

    always_comb begin
      cd_dec    = countdown[ch] - 16'd1;
      wrap      = (cd_dec == 16'd0);
      phase_new = phase[ch] ^ wrap;
      lvl[ch]   = (phase_new && !muted[ch]) ? volume[ch] : 4'd0;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        period[ch]    <= 12'd1;
        muted[ch]     <= 1'b1;
        volume[ch]    <= '0;
        countdown[ch] <= '0;
        phase[ch]     <= 1'b0;
      end else begin
        if (adv && tick) begin
          countdown[ch] <= wrap ? {period[ch], 4'b0000} : cd_dec;
          phase[ch]     <= phase_new;
        end
        if (aud_wr) begin
          if (audio_select == 4'(2 * ch)) begin
            period[ch] <= {period[ch][11:8], item.data};
          end else if (audio_select == 4'(2 * ch + 1)) begin
            period[ch] <= {item.data[3:0], period[ch][7:0]};
          end else if (audio_select == cbm_pkg::AUD_MUTE) begin
            muted[ch] <= item.data[ch];
          end else if (audio_select == 4'(cbm_pkg::AUD_VOL0 + 4'(ch))) begin
            volume[ch] <= item.data[3:0];
          end
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int c = 0; c < TONE_CHANNELS; c++) begin
      sum = sum + {1'b0, cbm_pkg::LEVEL_TABLE[lvl[c]]};
    end
    sample_next = tick ? (16'd0 - {1'b0, sum}) : 16'sd0;
  end

endmodule

/* rtl/cartridge_bank_mapper_with_tone_audio.sv */
`timescale 1ns / 1ps
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle while the result stage is not stalled; every item is done
// in a single pass of logic between the input register and the result register.
// Reset (synchronous, active high): both stages empty, all bank, IRQ and tone
// registers at their power-up values (periods 1, tones muted, IRQ level low).
module cartridge_bank_mapper_with_tone_audio #(
  parameter int TONE_CHANNELS = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         kind,
  input  logic [15:0]        address,
  input  logic [7:0]         data,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [2:0]         target,
  output logic [18:0]        mapped_address,
  output logic               ram_write,
  output logic               irq_line,
  output logic signed [15:0] sample
);

  logic               in_valid;
  cbm_pkg::item_t     in_item;
  logic               adv;

  cbm_pkg::target_t   target_next;
  logic [18:0]        mapped_next;
  logic               ram_write_next;
  logic               irq_line_next;
  logic signed [15:0] sample_next;
  cbm_pkg::irq_wr_t   irq_wr;

  assign adv        = in_valid && (!result_valid || !result_stall);
  assign item_stall = in_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_stall) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_item.kind    <= cbm_pkg::kind_t'(kind);
      in_item.address <= address;
      in_item.data    <= data;
    end
  end

  cbm_map u_map (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .item           (in_item),
    .target_next    (target_next),
    .mapped_next    (mapped_next),
    .ram_write_next (ram_write_next),
    .irq_wr         (irq_wr)
  );

  cbm_irq u_irq (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .tick       (in_item.kind == cbm_pkg::KIND_TICK),
    .irq_wr     (irq_wr),
    .level_next (irq_line_next)
  );

  cbm_tone #(
    .TONE_CHANNELS (TONE_CHANNELS)
  ) u_tone (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .item        (in_item),
    .sample_next (sample_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      target         <= target_next;
      mapped_address <= mapped_next;
      ram_write      <= ram_write_next;
      irq_line       <= irq_line_next;
      sample         <= sample_next;
    end
  end

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> in_valid && result_valid && result_stall)
    else $error("input stalled while result stage free");

  a_adv_fills: assert property (@(posedge clk) disable iff (rst)
    adv |=> result_valid)
    else $error("transfer into result stage lost");

  a_sample_only_tick: assert property (@(posedge clk) disable iff (rst)
    result_valid && (target != 3'(cbm_pkg::TGT_NONE)) |-> (sample == 16'sd0))
    else $error("nonzero sample on a bus access");

endmodule
